// ===== src/vn_pkg.sv =====
// Shared types and constants for the 3D vector normalization pipeline.
package vn_pkg;

    localparam int COMP_W    = 32;
    localparam int UNIT_FRAC = 30;
    localparam int SQ_STEPS  = COMP_W;
    localparam int DIV_STEPS = UNIT_FRAC + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_in;
        logic signed [COMP_W-1:0] y_in;
        logic signed [COMP_W-1:0] z_in;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_unit;
        logic signed [COMP_W-1:0] y_unit;
        logic signed [COMP_W-1:0] z_unit;
        logic        [COMP_W-1:0] magnitude;
        logic                     was_zero;
    } t_vec_out;

endpackage

// ===== src/vector3_normalize_unit.sv =====
// Top level of the 3D vector normalization pipeline.

// One vector enters per clock cycle whenever busy is low, which holds once the alive
// register has been set after reset. Each vector gives one result, marked by o_done for
// one cycle, after it passes registers for absolute values, squares and their sum, the
// bit-per-stage square root, the three bit-per-stage dividers and one output register.
// Results leave in input order and cannot be held off by the receiver.
module vector3_normalize_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  vn_pkg::t_vec_in    i_vec,
    output logic               o_busy,
    output logic               o_done,
    output vn_pkg::t_vec_out   o_vec
);

    localparam int W  = vn_pkg::COMP_W;
    localparam int NS = vn_pkg::SQ_STEPS;
    localparam int ND = vn_pkg::DIV_STEPS;
    localparam int QW = vn_pkg::DIV_STEPS;

    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][W-1:0]     mag;
    } t_front;

    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][W-1:0]     mag;
        logic [2:0][2*W-1:0]   sq;
    } t_square;

    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][W-1:0]     mag;
        logic [2*W-1:0]        rad;
        logic [W-1:0]          root;
        logic [W+1:0]          rem;
    } t_sq_stage;

    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic [2:0]            neg;
        logic [W-1:0]          len;
        logic [2:0][W-1:0]     rem;
        logic [2:0][QW-1:0]    quo;
    } t_dv_stage;

    logic              r_alive;
    t_front            r_s1;
    t_front            n_s1;
    t_square           r_s2;
    t_sq_stage         r_s3;
    t_sq_stage         r_sq [NS];
    t_sq_stage         n_sq [NS];
    t_sq_stage         sq_src [NS];
    t_dv_stage         r_dv [ND];
    t_dv_stage         n_dv [ND];
    t_dv_stage         dv_src [ND];
    logic              r_done;
    vn_pkg::t_vec_out  r_out;
    vn_pkg::t_vec_out  n_out;

    assign o_busy = !r_alive;
    assign o_done = r_done;
    assign o_vec  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else begin
            r_alive <= 1'b1;
        end
    end

    always_comb begin
        logic [2:0][W-1:0] raw;
        raw = {i_vec.x_in, i_vec.y_in, i_vec.z_in};
        n_s1.vld = i_start && r_alive;
        for (int c = 0; c < 3; c++) begin
            n_s1.neg[c] = raw[c][W-1];
            n_s1.mag[c] = raw[c][W-1] ? (~raw[c] + W'(1)) : raw[c];
        end
        n_s1.zero = (raw == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2.vld  <= r_s1.vld;
            r_s2.zero <= r_s1.zero;
            r_s2.neg  <= r_s1.neg;
            r_s2.mag  <= r_s1.mag;
            for (int c = 0; c < 3; c++) begin
                r_s2.sq[c] <= r_s1.mag[c] * r_s1.mag[c];
            end
            r_s3.vld  <= r_s2.vld;
            r_s3.zero <= r_s2.zero;
            r_s3.neg  <= r_s2.neg;
            r_s3.mag  <= r_s2.mag;
            r_s3.rad  <= r_s2.sq[0] + r_s2.sq[1] + r_s2.sq[2];
            r_s3.root <= '0;
            r_s3.rem  <= '0;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        if (k == 0) begin : g_first
            assign sq_src[k] = r_s3;
        end else begin : g_next
            assign sq_src[k] = r_sq[k-1];
        end

        always_comb begin
            logic [W+3:0] t_rem;
            logic [W+3:0] trial;
            logic [W+3:0] diff;
            logic         ge;
            t_rem = {sq_src[k].rem, sq_src[k].rad[2*W-1 -: 2]};
            trial = {2'b00, sq_src[k].root, 2'b01};
            diff  = t_rem - trial;
            ge    = (t_rem >= trial);
            n_sq[k]      = sq_src[k];
            n_sq[k].rad  = {sq_src[k].rad[2*W-3:0], 2'b00};
            n_sq[k].root = {sq_src[k].root[W-2:0], ge};
            n_sq[k].rem  = ge ? diff[W+1:0] : t_rem[W+1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k].vld <= 1'b0;
            end else begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        if (j == 0) begin : g_first
            assign dv_src[j] = {r_sq[NS-1].vld, r_sq[NS-1].zero, r_sq[NS-1].neg,
                                r_sq[NS-1].root, r_sq[NS-1].mag, {(3*QW){1'b0}}};
        end else begin : g_next
            assign dv_src[j] = r_dv[j-1];
        end

        always_comb begin
            logic [W:0] t_div;
            logic [W:0] diff;
            logic       ge;
            n_dv[j] = dv_src[j];
            for (int c = 0; c < 3; c++) begin
                t_div = (j == 0) ? {1'b0, dv_src[j].rem[c]} : {dv_src[j].rem[c], 1'b0};
                ge    = (t_div >= {1'b0, dv_src[j].len});
                diff  = t_div - {1'b0, dv_src[j].len};
                n_dv[j].rem[c] = ge ? diff[W-1:0] : t_div[W-1:0];
                n_dv[j].quo[c] = {dv_src[j].quo[c][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j].vld <= 1'b0;
            end else begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    always_comb begin
        logic [2:0][W-1:0] unit;
        for (int c = 0; c < 3; c++) begin
            unit[c] = r_dv[ND-1].neg[c] ? (W'(0) - W'(r_dv[ND-1].quo[c]))
                                         : W'(r_dv[ND-1].quo[c]);
            if (r_dv[ND-1].zero) begin
                unit[c] = '0;
            end
        end
        n_out.x_unit    = unit[2];
        n_out.y_unit    = unit[1];
        n_out.z_unit    = unit[0];
        n_out.magnitude = r_dv[ND-1].zero ? '0 : r_dv[ND-1].len;
        n_out.was_zero  = r_dv[ND-1].zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[ND-1].vld;
            r_out  <= n_out;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for vector3_normalize_unit with directed and random vectors.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 100;
    localparam int RAND_ITEMS  = 800;
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 449;
    localparam int DRAIN_AT    = 500;
    localparam int IDLE_PCT    = 26;

    localparam logic [31:0] UNIT_POS = 32'h4000_0000;
    localparam logic [31:0] UNIT_NEG = 32'hC000_0000;

    typedef enum int {CK_FULL, CK_SMALL, CK_EXTREME, CK_ZERO} t_comp_kind;

    typedef struct {
        vn_pkg::t_vec_in  vec;
        bit               typed;
        vn_pkg::t_vec_out res;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_start;
    vn_pkg::t_vec_in  i_vec;
    logic             o_busy;
    logic             o_done;
    vn_pkg::t_vec_out o_vec;

    vn_pkg::t_vec_out norm_expected[$];
    t_stim_row        dir_rows[$];
    int               mismatch_count = 0;
    int               quiet_cycles = 0;

    vector3_normalize_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_vec   (i_vec),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_vec   (o_vec)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] abs_comp(logic [31:0] c);
        logic [31:0] m;
        m = c[31] ? (~c + 32'd1) : c;
        return {32'd0, m};
    endfunction

    function automatic logic [63:0] floor_sqrt64(logic [63:0] s);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = s;
        root = '0;
        b    = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_comp(logic [31:0] c, logic [63:0] a,
                                              logic [63:0] len);
        logic [63:0] q;
        q = (a << vn_pkg::UNIT_FRAC) / len;
        if (c[31])
            q = ~q + 64'd1;
        return q[31:0];
    endfunction

    function automatic vn_pkg::t_vec_out normalize_vec(vn_pkg::t_vec_in v);
        logic [63:0]      ax;
        logic [63:0]      ay;
        logic [63:0]      az;
        logic [63:0]      sq_sum;
        logic [63:0]      len;
        vn_pkg::t_vec_out r;
        ax     = abs_comp(v.x_in);
        ay     = abs_comp(v.y_in);
        az     = abs_comp(v.z_in);
        sq_sum = ax * ax + ay * ay + az * az;
        r      = '0;
        if (sq_sum == 0) begin
            r.was_zero = 1'b1;
        end else begin
            len         = floor_sqrt64(sq_sum);
            r.x_unit    = unit_comp(v.x_in, ax, len);
            r.y_unit    = unit_comp(v.y_in, ay, len);
            r.z_unit    = unit_comp(v.z_in, az, len);
            r.magnitude = len[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_comp(t_comp_kind kind);
        logic [31:0] c;
        case (kind)
            CK_FULL: begin
                c = $urandom;
            end
            CK_SMALL: begin
                c = $urandom_range(0, 32'h000F_FFFF);
                if ($urandom_range(0, 1) == 1)
                    c = -c;
            end
            CK_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: c = 32'h0000_0000;
                    1: c = 32'h0000_0001;
                    2: c = 32'hFFFF_FFFF;
                    3: c = 32'h7FFF_FFFF;
                    default: c = 32'h8000_0000;
                endcase
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input bit typed, input logic [31:0] ux, input logic [31:0] uy,
                           input logic [31:0] uz, input logic [31:0] mag, input logic wz);
        t_stim_row row;
        row.vec.x_in         = x;
        row.vec.y_in         = y;
        row.vec.z_in         = z;
        row.typed            = typed;
        row.res.x_unit       = ux;
        row.res.y_unit       = uy;
        row.res.z_unit       = uz;
        row.res.magnitude    = mag;
        row.res.was_zero     = wz;
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_vec(input vn_pkg::t_vec_in v, input vn_pkg::t_vec_out want);
        i_start <= 1'b1;
        i_vec   <= v;
        do
            @(posedge i_clk);
        while (o_busy);
        norm_expected.push_back(want);
    endtask

    task automatic idle_cycle();
        i_start <= 1'b0;
        i_vec   <= {$urandom, $urandom, $urandom};
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_start <= 1'b0;
        while (norm_expected.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        vn_pkg::t_vec_out want;
        if (i_rst_n && o_done) begin
            if (norm_expected.size() == 0) begin
                report_mismatch("result with no beat pending, magnitude", o_vec.magnitude, '0);
            end else begin
                want = norm_expected.pop_front();
                if (o_vec.x_unit !== want.x_unit)
                    report_mismatch("x_unit", o_vec.x_unit, want.x_unit);
                if (o_vec.y_unit !== want.y_unit)
                    report_mismatch("y_unit", o_vec.y_unit, want.y_unit);
                if (o_vec.z_unit !== want.z_unit)
                    report_mismatch("z_unit", o_vec.z_unit, want.z_unit);
                if (o_vec.magnitude !== want.magnitude)
                    report_mismatch("magnitude", o_vec.magnitude, want.magnitude);
                if (o_vec.was_zero !== want.was_zero)
                    report_mismatch("was_zero", {31'd0, o_vec.was_zero}, {31'd0, want.was_zero});
            end
        end
        if (i_rst_n && ((i_start && !o_busy) || o_done))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired with %0d results pending", norm_expected.size());
            $display("vector3_normalize_unit test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_comp_kind      kinds[3];
        vn_pkg::t_vec_in v;
        int              mode;
        int              axis;

        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_vec   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
                32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        add_row(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1,
                UNIT_POS, 32'h0, 32'h0, 32'h0000_0001, 1'b0);
        add_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                32'h0, UNIT_NEG, 32'h0, 32'h0000_0001, 1'b0);
        add_row(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1,
                32'h0, 32'h0, UNIT_POS, 32'h7FFF_FFFF, 1'b0);
        add_row(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
                UNIT_NEG, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
        add_row(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1,
                32'h0, UNIT_NEG, 32'h0, 32'h8000_0000, 1'b0);
        add_row(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1,
                32'h0, 32'h0, UNIT_NEG, 32'h8000_0000, 1'b0);
        add_row(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1,
                UNIT_POS, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
        add_row(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1,
                32'h0, UNIT_POS, 32'h0, 32'h0001_0000, 1'b0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'hFFFD_0000, 32'h0000_0000, 32'h0004_0000, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 1'b0, '0, '0, '0, '0, 1'b0);
        add_row(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0, '0, '0, '0, '0, 1'b0);

        foreach (dir_rows[i]) begin
            while ($urandom_range(0, 99) < IDLE_PCT)
                idle_cycle();
            send_vec(dir_rows[i].vec,
                     dir_rows[i].typed ? dir_rows[i].res : normalize_vec(dir_rows[i].vec));
        end
        wait_drain();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 40) begin
                kinds = '{CK_FULL, CK_FULL, CK_FULL};
            end else if (mode < 65) begin
                kinds = '{CK_SMALL, CK_SMALL, CK_SMALL};
            end else if (mode < 80) begin
                foreach (kinds[k])
                    kinds[k] = t_comp_kind'($urandom_range(0, 3));
            end else if (mode < 92) begin
                kinds = '{CK_ZERO, CK_ZERO, CK_ZERO};
                axis = $urandom_range(0, 2);
                if ($urandom_range(0, 1) == 1)
                    kinds[axis] = CK_FULL;
                else
                    kinds[axis] = CK_SMALL;
            end else if (mode < 96) begin
                kinds = '{CK_ZERO, CK_ZERO, CK_ZERO};
            end else begin
                kinds = '{CK_EXTREME, CK_EXTREME, CK_EXTREME};
            end
            v.x_in = rand_comp(kinds[0]);
            v.y_in = rand_comp(kinds[1]);
            v.z_in = rand_comp(kinds[2]);

            if (n == DRAIN_AT)
                wait_drain();
            if (n < CALM_FIRST || n > CALM_LAST) begin
                while ($urandom_range(0, 99) < IDLE_PCT)
                    idle_cycle();
            end
            send_vec(v, normalize_vec(v));
        end

        wait_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("vector3_normalize_unit test passed");
        else
            $display("vector3_normalize_unit test failed");
        $finish;
    end

endmodule
